### design/tlpt_pkg.sv
// ----------------------------------------------------------------------------
// tlpt_pkg
// Types and constants shared by the two-level page table engine.
// ----------------------------------------------------------------------------
package tlpt_pkg;

  localparam int unsigned TABLE_WORDS = 1024;
  localparam int unsigned DIR_WORDS   = 1024;
  localparam int unsigned IDX_W       = 10;
  localparam int unsigned FRAME_W     = 20;
  localparam int unsigned OFFS_W      = 12;
  localparam int unsigned VA_W        = 32;
  localparam logic [FRAME_W-1:0] FRAME_BASE_RST = 20'd256;

  typedef enum logic [1:0] {
    OP_MAP    = 2'd0,
    OP_UNMAP  = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_FAULT  = 2'd3
  } tlpt_op_e;

  typedef struct packed {
    tlpt_op_e          op;
    logic [VA_W-1:0]   virt_addr;
    logic [VA_W-1:0]   phys_addr;
    logic [OFFS_W-1:0] entry_flags;
  } tlpt_in_t;

  typedef struct packed {
    logic               status;
    logic [VA_W-1:0]    phys_out;
    logic               mapped;
    logic               dirty;
    logic               accessed;
    logic [FRAME_W-1:0] fault_frame;
    logic               invalidate;
  } tlpt_out_t;

  // Page table entry as held in the table memory: only the fields that
  // can ever be observed are kept.
  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               dirty;
    logic               accessed;
    logic               present;
  } tlpt_pte_t;

  typedef struct packed {
    logic             load;
    logic             clr_dir;
    logic             decide;
    logic             clr_tbl;
    logic             ent_wr;
    logic             finish;
    logic             fail;
    logic [IDX_W-1:0] cnt;
  } tlpt_cmd_t;

  typedef struct packed {
    logic absent;
    logic ok;
    logic rd_op;
    logic is_unmap;
  } tlpt_sts_t;

endpackage

### design/tlpt_ram.sv
// ----------------------------------------------------------------------------
// tlpt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tlpt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/tlpt_ctrl.sv
// ----------------------------------------------------------------------------
// tlpt_ctrl
// Sequencer: directory clearing, lookup, table allocation and entry update.
// ----------------------------------------------------------------------------
module tlpt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                cfg_we_i,
  input  tlpt_pkg::tlpt_sts_t sts_i,
  output tlpt_pkg::tlpt_cmd_t cmd_o,
  output logic                done_o
);
  import tlpt_pkg::*;

  typedef enum logic [2:0] {
    ST_CLR_DIR,
    ST_IDLE,
    ST_DIR,
    ST_DECIDE,
    ST_CLR_TBL,
    ST_ENT,
    ST_ENT_WAIT
  } state_e;

  state_e           state_q;
  logic [IDX_W-1:0] cnt_q;
  logic             done_q;
  tlpt_cmd_t        cmd;

  always_comb begin
    cmd     = '0;
    cmd.cnt = cnt_q;
    case (state_q)
      ST_CLR_DIR: cmd.clr_dir = 1'b1;
      ST_IDLE:    cmd.load    = start;
      ST_DECIDE: begin
        if (sts_i.ok) begin
          cmd.decide = 1'b1;
        end else begin
          cmd.fail   = 1'b1;
          cmd.finish = 1'b1;
        end
      end
      ST_CLR_TBL: cmd.clr_tbl = 1'b1;
      ST_ENT: begin
        if (!sts_i.rd_op) begin
          cmd.ent_wr = 1'b1;
          cmd.finish = 1'b1;
        end
      end
      ST_ENT_WAIT: begin
        cmd.ent_wr = sts_i.is_unmap;
        cmd.finish = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR_DIR;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= cmd.finish;
      if (cfg_we_i) begin
        state_q <= ST_CLR_DIR;
        cnt_q   <= '0;
      end else begin
        case (state_q)
          ST_CLR_DIR: begin
            cnt_q <= cnt_q + 1'b1;
            if (cnt_q == '1) begin
              state_q <= ST_IDLE;
            end
          end
          ST_IDLE: begin
            if (start) begin
              state_q <= ST_DIR;
            end
          end
          ST_DIR: state_q <= ST_DECIDE;
          ST_DECIDE: begin
            if (!sts_i.ok) begin
              state_q <= ST_IDLE;
            end else if (sts_i.absent) begin
              cnt_q   <= '0;
              state_q <= ST_CLR_TBL;
            end else begin
              state_q <= ST_ENT;
            end
          end
          ST_CLR_TBL: begin
            cnt_q <= cnt_q + 1'b1;
            if (cnt_q == '1) begin
              state_q <= ST_ENT;
            end
          end
          ST_ENT: begin
            state_q <= sts_i.rd_op ? ST_ENT_WAIT : ST_IDLE;
          end
          ST_ENT_WAIT: state_q <= ST_IDLE;
          default:     state_q <= ST_IDLE;
        endcase
      end
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign cmd_o  = cmd;
  assign done_o = done_q;

endmodule

### design/tlpt_dpath.sv
// ----------------------------------------------------------------------------
// tlpt_dpath
// Datapath: operand registers, frame allocator, directory and table memories.
// ----------------------------------------------------------------------------
module tlpt_dpath #(
  parameter int unsigned POOL_FRAMES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tlpt_pkg::tlpt_cmd_t           cmd_i,
  input  tlpt_pkg::tlpt_in_t            item_i,
  input  logic                          cfg_we_i,
  input  logic [tlpt_pkg::FRAME_W-1:0]  cfg_wdata_i,
  output tlpt_pkg::tlpt_sts_t           sts_o,
  output tlpt_pkg::tlpt_out_t           result_o
);
  import tlpt_pkg::*;

  localparam int unsigned SLOT_W = $clog2(POOL_FRAMES);
  localparam int unsigned CNT_W  = $clog2(POOL_FRAMES + 1);
  localparam int unsigned DIR_W  = SLOT_W + 1;
  localparam int unsigned PTE_W  = $bits(tlpt_pte_t);
  localparam int unsigned TBL_AW = SLOT_W + IDX_W;

  tlpt_in_t           item_q;
  logic [FRAME_W-1:0] frame_base_q;
  logic [CNT_W-1:0]   used_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [FRAME_W-1:0] nf_q;
  tlpt_out_t          res_q;

  logic [IDX_W-1:0]   dir_idx;
  logic [IDX_W-1:0]   tbl_idx;
  logic [DIR_W-1:0]   dir_rdata;
  logic               absent;
  logic               is_fault;
  logic [CNT_W:0]     used_sum;
  logic [CNT_W-1:0]   fresh;
  logic [SLOT_W-1:0]  fresh_slot;
  logic               dir_we;
  logic [IDX_W-1:0]   dir_waddr;
  logic [DIR_W-1:0]   dir_wdata;
  logic               tbl_we;
  logic [TBL_AW-1:0]  tbl_waddr;
  tlpt_pte_t          tbl_wdata;
  tlpt_pte_t          tbl_rdata;
  logic [PTE_W-1:0]   tbl_rdata_raw;
  tlpt_out_t          res_d;

  assign dir_idx  = item_q.virt_addr[VA_W-1 -: IDX_W];
  assign tbl_idx  = item_q.virt_addr[OFFS_W +: IDX_W];
  assign absent   = ~dir_rdata[SLOT_W];
  assign is_fault = (item_q.op == OP_FAULT);

  // A fault takes its data frame first; a missing table takes the next one.
  assign used_sum   = {1'b0, used_q} + (CNT_W + 1)'(absent) + (CNT_W + 1)'(is_fault);
  assign fresh      = used_q + CNT_W'(is_fault);
  assign fresh_slot = fresh[SLOT_W-1:0];

  assign sts_o.absent   = absent;
  assign sts_o.ok       = (used_sum <= (CNT_W + 1)'(POOL_FRAMES));
  assign sts_o.rd_op    = (item_q.op == OP_UNMAP) || (item_q.op == OP_LOOKUP);
  assign sts_o.is_unmap = (item_q.op == OP_UNMAP);

  assign dir_we    = cmd_i.clr_dir | (cmd_i.decide & absent);
  assign dir_waddr = cmd_i.clr_dir ? cmd_i.cnt : dir_idx;
  assign dir_wdata = cmd_i.clr_dir ? '0 : {1'b1, fresh_slot};

  tlpt_ram #(
    .WIDTH (DIR_W),
    .DEPTH (DIR_WORDS)
  ) u_dir_ram (
    .clk_i   (clk_i),
    .we_i    (dir_we),
    .waddr_i (dir_waddr),
    .wdata_i (dir_wdata),
    .raddr_i (dir_idx),
    .rdata_o (dir_rdata)
  );

  always_comb begin
    tbl_wdata = tbl_rdata;
    case (item_q.op)
      OP_MAP: begin
        tbl_wdata.frame    = item_q.phys_addr[VA_W-1:OFFS_W];
        tbl_wdata.dirty    = item_q.entry_flags[6];
        tbl_wdata.accessed = item_q.entry_flags[5];
        tbl_wdata.present  = 1'b1;
      end
      OP_FAULT: begin
        tbl_wdata.frame    = nf_q;
        tbl_wdata.dirty    = 1'b0;
        tbl_wdata.accessed = 1'b0;
        tbl_wdata.present  = 1'b1;
      end
      OP_UNMAP: tbl_wdata.present = 1'b0;
      default:  tbl_wdata = tbl_rdata;
    endcase
    if (cmd_i.clr_tbl) begin
      tbl_wdata = '0;
    end
  end

  assign tbl_we    = cmd_i.clr_tbl | cmd_i.ent_wr;
  assign tbl_waddr = {slot_q, (cmd_i.clr_tbl ? cmd_i.cnt : tbl_idx)};
  assign tbl_rdata = tlpt_pte_t'(tbl_rdata_raw);

  tlpt_ram #(
    .WIDTH (PTE_W),
    .DEPTH (POOL_FRAMES * TABLE_WORDS)
  ) u_tbl_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i ({slot_q, tbl_idx}),
    .rdata_o (tbl_rdata_raw)
  );

  always_comb begin
    res_d = '0;
    if (cmd_i.fail) begin
      res_d.status = 1'b1;
      if (item_q.op == OP_LOOKUP) begin
        res_d.phys_out = '1;
      end
    end else begin
      case (item_q.op)
        OP_LOOKUP: begin
          res_d.mapped   = tbl_rdata.present;
          res_d.dirty    = tbl_rdata.dirty;
          res_d.accessed = tbl_rdata.accessed;
          res_d.phys_out = tbl_rdata.present ?
                           {tbl_rdata.frame, item_q.virt_addr[OFFS_W-1:0]} : '1;
        end
        OP_UNMAP: res_d.invalidate  = 1'b1;
        OP_FAULT: res_d.fault_frame = nf_q;
        default:  res_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_base_q <= FRAME_BASE_RST;
      used_q       <= '0;
    end else if (cfg_we_i) begin
      frame_base_q <= cfg_wdata_i;
      used_q       <= '0;
    end else if (cmd_i.decide) begin
      used_q <= used_sum[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
    if (cmd_i.decide) begin
      nf_q   <= frame_base_q + FRAME_W'(1) + FRAME_W'(used_q);
      slot_q <= absent ? fresh_slot : dir_rdata[SLOT_W-1:0];
    end
    if (cmd_i.finish) begin
      res_q <= res_d;
    end
  end

  assign result_o = res_q;

endmodule

### design/two_level_page_table_engine.sv
// ----------------------------------------------------------------------------
// two_level_page_table_engine
// A result strobes after the directory read, the allocation decision, a clear
// of the new 1024-word table when the directory slot is empty, and the entry
// access; unmap and lookup add a wait state, an out-of-frames error ends early.
// Throughput: one transaction at a time; the controller accepts the next one
// only once it has returned to idle.
// Reset, and every frame_base write, runs a clear of the 1024-word directory
// with busy high. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module two_level_page_table_engine #(
  parameter int unsigned POOL_FRAMES = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  tlpt_pkg::tlpt_in_t           item_i,
  output logic                         done_o,
  output tlpt_pkg::tlpt_out_t          result_o,
  input  logic                         cfg_we_i,
  input  logic [tlpt_pkg::FRAME_W-1:0] cfg_wdata_i
);
  import tlpt_pkg::*;

  // The controller sequences each transaction: directory read, the
  // allocation decision, an optional table clear, then the entry access.
  // It drives the datapath only through the command structure and reads
  // back a handful of status flags.
  tlpt_cmd_t cmd;
  tlpt_sts_t sts;

  tlpt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .cfg_we_i (cfg_we_i),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .done_o   (done_o)
  );

  // The datapath holds the directory (present bit plus pool slot per entry)
  // and the table store, one 1024-word region per pool frame. Frames are
  // handed out by a bump counter; the frame number is rebuilt from the base
  // register and the slot, so allocated frames wrap modulo 2^20.
  tlpt_dpath #(
    .POOL_FRAMES (POOL_FRAMES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sts_o       (sts),
    .result_o    (result_o)
  );

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-level page table engine. A short scripted
// sequence covers the address and flag extremes, each operation, table
// allocation on every operation, frame wrap-round and re-basing. A phased
// random run follows: each phase re-bases the frame pool and then issues
// transactions over a small set of directory and table slots, with some
// phases biased towards page faults so that the pool runs dry. Every result
// is checked against a behavioural page-walk model kept inside the bench.
// ----------------------------------------------------------------------------
module tb;

  import tlpt_pkg::*;

  // The pool size the engine is built with; the model must agree with it.
  localparam int unsigned POOL       = 64;
  localparam int unsigned N_PHASES   = 12;
  // Watchdog limit on the length of the run, in clock cycles.
  localparam longint unsigned CYCLE_LIMIT = 3_000_000;

  // Results that can be read straight off the behaviour.
  localparam tlpt_out_t R_DONE  = '0;
  localparam tlpt_out_t R_MISS  = '{phys_out: '1, default: '0};
  localparam tlpt_out_t R_INVAL = '{invalidate: 1'b1, default: '0};
  localparam tlpt_out_t R_FULL  = '{phys_out: '1, mapped: 1'b1, dirty: 1'b1,
                                    accessed: 1'b1, default: '0};

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  tlpt_in_t            item_i;
  logic                done_o;
  tlpt_out_t           result_o;
  logic                cfg_we_i;
  logic [FRAME_W-1:0]  cfg_wdata_i;

  two_level_page_table_engine #(
    .POOL_FRAMES(POOL)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Page-walk model. It keeps its own copy of the directory, of the table
  // frames in the pool and of the bump allocator.
  // --------------------------------------------------------------------------
  logic [31:0]        dir_mem [DIR_WORDS];
  logic [31:0]        tbl_mem [POOL*TABLE_WORDS];
  logic [FRAME_W-1:0] base_frame;
  logic [FRAME_W-1:0] nxt_frame;

  // Frame arithmetic is modulo 2^20, so a pool may wrap round frame zero.
  function automatic int unsigned slot_of(logic [FRAME_W-1:0] frame);
    logic [FRAME_W-1:0] s;
    s = frame - base_frame - 20'd1;
    return (s < POOL) ? int'(s) : POOL;
  endfunction

  function automatic int unsigned free_frames();
    logic [FRAME_W-1:0] used;
    used = nxt_frame - base_frame - 20'd1;
    return (used < POOL) ? POOL - int'(used) : 0;
  endfunction

  // Hands out the next frame and clears it, as the engine does.
  function automatic logic [FRAME_W-1:0] grab_frame();
    int unsigned        slot;
    logic [FRAME_W-1:0] f;
    slot = slot_of(nxt_frame);
    f    = nxt_frame;
    if (slot < POOL) begin
      for (int w = 0; w < TABLE_WORDS; w++) tbl_mem[slot*TABLE_WORDS + w] = '0;
    end
    nxt_frame = nxt_frame + 20'd1;
    return f;
  endfunction

  // Finds the table of an address, allocating it when the slot is empty.
  function automatic int unsigned table_slot(logic [VA_W-1:0] va);
    logic [FRAME_W-1:0] f;
    if (!dir_mem[va[31:22]][0]) begin
      f = grab_frame();
      dir_mem[va[31:22]] = {f, 12'h001};
      return slot_of(f);
    end
    return slot_of(dir_mem[va[31:22]][31:12]);
  endfunction

  function automatic logic [31:0] get_entry(int unsigned slot, logic [IDX_W-1:0] ti);
    return (slot < POOL) ? tbl_mem[slot*TABLE_WORDS + ti] : 32'd0;
  endfunction

  function automatic void put_entry(int unsigned slot, logic [IDX_W-1:0] ti,
                                    logic [31:0] v);
    if (slot < POOL) tbl_mem[slot*TABLE_WORDS + ti] = v;
  endfunction

  function automatic void rebase(logic [FRAME_W-1:0] v);
    base_frame = v;
    nxt_frame  = v + 20'd1;
    for (int d = 0; d < DIR_WORDS; d++) dir_mem[d] = '0;
  endfunction

  // Works out the result of one transaction and updates the model state.
  function automatic tlpt_out_t page_walk(tlpt_in_t cmd);
    tlpt_out_t        r;
    logic [IDX_W-1:0] ti;
    int unsigned      need;
    int unsigned      s;
    logic [31:0]      e;
    r    = '0;
    ti   = cmd.virt_addr[21:12];
    need = (dir_mem[cmd.virt_addr[31:22]][0] ? 0 : 1) + (cmd.op == OP_FAULT ? 1 : 0);
    if (need > free_frames()) begin
      // Pool exhausted: nothing changes, a lookup still reports a miss.
      r.status = 1'b1;
      if (cmd.op == OP_LOOKUP) r.phys_out = '1;
    end else begin
      case (cmd.op)
        OP_MAP: begin
          s = table_slot(cmd.virt_addr);
          put_entry(s, ti, {cmd.phys_addr[31:12], cmd.entry_flags} | 32'd1);
        end
        OP_UNMAP: begin
          // Only the present bit goes; the flags stay behind.
          s = table_slot(cmd.virt_addr);
          put_entry(s, ti, get_entry(s, ti) & ~32'd1);
          r.invalidate = 1'b1;
        end
        OP_LOOKUP: begin
          s = table_slot(cmd.virt_addr);
          e = get_entry(s, ti);
          r.mapped   = e[0];
          r.dirty    = e[6];
          r.accessed = e[5];
          r.phys_out = e[0] ? {e[31:12], cmd.virt_addr[11:0]} : '1;
        end
        default: begin
          // The faulting page takes its frame before any table is allocated.
          r.fault_frame = grab_frame();
          s = table_slot(cmd.virt_addr);
          put_entry(s, ti, {r.fault_frame, 12'h001});
        end
      endcase
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking.
  // --------------------------------------------------------------------------
  tlpt_out_t       pending_q[$];
  tlpt_out_t       head_res;
  int unsigned     fail_cnt;
  longint unsigned cycle_cnt;

  task automatic report(string msg);
    $display("ERROR at %0t ns: %s", $realtime, msg);
    fail_cnt++;
  endtask

  // The watchdog shares this process with the checker; the else keeps the
  // checker out of reach once the run has been stopped.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else if (rst_ni && done_o) begin
      if (pending_q.size() == 0) begin
        report("result strobe with no transaction outstanding");
      end else begin
        head_res = pending_q.pop_front();
        if (result_o.status !== head_res.status)
          report($sformatf("status %b, expected %b", result_o.status, head_res.status));
        if (result_o.phys_out !== head_res.phys_out)
          report($sformatf("phys_out %h, expected %h", result_o.phys_out,
                           head_res.phys_out));
        if (result_o.mapped !== head_res.mapped)
          report($sformatf("mapped %b, expected %b", result_o.mapped, head_res.mapped));
        if (result_o.dirty !== head_res.dirty)
          report($sformatf("dirty %b, expected %b", result_o.dirty, head_res.dirty));
        if (result_o.accessed !== head_res.accessed)
          report($sformatf("accessed %b, expected %b", result_o.accessed,
                           head_res.accessed));
        if (result_o.fault_frame !== head_res.fault_frame)
          report($sformatf("fault_frame %h, expected %h", result_o.fault_frame,
                           head_res.fault_frame));
        if (result_o.invalidate !== head_res.invalidate)
          report($sformatf("invalidate %b, expected %b", result_o.invalidate,
                           head_res.invalidate));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driving. All tasks are entered and left at a falling edge.
  // --------------------------------------------------------------------------

  // Presents one transaction and holds it until the engine takes it. The
  // expectation is queued at the following falling edge, well before the
  // earliest possible result, so queueing never meets a pop in one step.
  task automatic send_item(tlpt_in_t cmd, bit typed, tlpt_out_t want);
    tlpt_out_t pred;
    start  <= 1'b1;
    item_i <= cmd;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pred = page_walk(cmd);
    @(negedge clk_i);
    pending_q.push_back(typed ? want : pred);
  endtask

  // Drops start and waits until every result is in and the engine is idle.
  // At least one edge passes, so start is never lowered and raised in the
  // same step.
  task automatic wait_idle();
    start <= 1'b0;
    do @(negedge clk_i); while (pending_q.size() != 0 || busy);
  endtask

  // Re-bases the pool. The engine then clears its directory with busy high,
  // which the next transaction simply waits out.
  task automatic set_frame_base(logic [FRAME_W-1:0] v);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    rebase(v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Scripted sequence. A row either re-bases the pool or carries one
  // transaction; the expected result is written in only where it is obvious.
  // --------------------------------------------------------------------------
  typedef struct {
    bit                 is_cfg;
    logic [FRAME_W-1:0] base;
    tlpt_in_t           cmd;
    bit                 typed;
    tlpt_out_t          want;
  } script_row_t;

  script_row_t script[$];

  function automatic void add_step(tlpt_op_e op, logic [31:0] va, logic [31:0] pa,
                                   logic [11:0] fl, bit typed, tlpt_out_t want);
    script_row_t r;
    r.is_cfg = 1'b0;
    r.base   = '0;
    r.cmd    = '{op: op, virt_addr: va, phys_addr: pa, entry_flags: fl};
    r.typed  = typed;
    r.want   = want;
    script.push_back(r);
  endfunction

  function automatic void add_base(logic [FRAME_W-1:0] v);
    script_row_t r;
    r        = '{default: '0};
    r.is_cfg = 1'b1;
    r.base   = v;
    script.push_back(r);
  endfunction

  initial begin
    logic [IDX_W-1:0]  dirs [4];
    logic [IDX_W-1:0]  tix [6];
    int unsigned       n_items;
    int unsigned       dice;
    bit                fill;
    bit                idles;
    tlpt_in_t          cmd;
    logic [FRAME_W-1:0] base;

    rst_ni      = 1'b0;
    start       = 1'b0;
    item_i      = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = FRAME_BASE_RST;
    fail_cnt    = 0;
    cycle_cnt   = 0;
    for (int w = 0; w < POOL*TABLE_WORDS; w++) tbl_mem[w] = '0;
    rebase(FRAME_BASE_RST);

    // Lowest directory slot, empty: a lookup allocates the table and misses.
    add_step(OP_LOOKUP, 32'h0000_0000, 32'h0,          12'h000, 1, R_MISS);
    // All-ones frame and flags, then read back with the top offset.
    add_step(OP_MAP,    32'h0000_1ABC, 32'hFFFF_F123, 12'hFFF, 1, R_DONE);
    add_step(OP_LOOKUP, 32'h0000_1FFF, 32'h0,          12'h000, 1, R_FULL);
    add_step(OP_UNMAP,  32'h0000_1000, 32'h0,          12'h000, 1, R_INVAL);
    // After unmap the dirty and accessed flags are still visible.
    add_step(OP_LOOKUP, 32'h0000_1000, 32'h0,          12'h000, 0, R_DONE);
    // Fault in the top slot: the page frame, then the table frame, is taken.
    add_step(OP_FAULT,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF, 0, R_DONE);
    add_step(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0,          12'h000, 0, R_DONE);
    // Frame zero with no flags: present only.
    add_step(OP_MAP,    32'hFFC0_0000, 32'h0000_0000, 12'h000, 1, R_DONE);
    add_step(OP_LOOKUP, 32'hFFC0_0000, 32'h0,          12'h000, 0, R_DONE);
    // Dirty alone, then accessed alone.
    add_step(OP_MAP,    32'h0040_2000, 32'h8000_0000, 12'h040, 0, R_DONE);
    add_step(OP_LOOKUP, 32'h0040_2ABC, 32'h0,          12'h000, 0, R_DONE);
    add_step(OP_MAP,    32'h0040_3000, 32'h7FFF_F000, 12'h020, 0, R_DONE);
    add_step(OP_LOOKUP, 32'h0040_3555, 32'h0,          12'h000, 0, R_DONE);
    // Unmap in an empty slot still allocates a table.
    add_step(OP_UNMAP,  32'h8000_0000, 32'h0,          12'h000, 1, R_INVAL);
    // A fault over a page that was mapped and then unmapped maps it afresh.
    add_step(OP_FAULT,  32'h0000_1000, 32'h0,          12'h000, 0, R_DONE);
    add_step(OP_LOOKUP, 32'h0000_1234, 32'h0,          12'h000, 0, R_DONE);
    // The low bits of the physical address are dropped on map.
    add_step(OP_MAP,    32'h1234_5678, 32'h1234_5FFF, 12'h800, 0, R_DONE);
    add_step(OP_LOOKUP, 32'h1234_55A5, 32'h0,          12'h000, 0, R_DONE);
    // Top base: allocation wraps round to frame zero.
    add_base(20'hFFFFF);
    add_step(OP_FAULT,  32'h0000_0000, 32'h0,          12'h000, 0, R_DONE);
    add_step(OP_LOOKUP, 32'h0000_0FFF, 32'h0,          12'h000, 0, R_DONE);
    add_base(20'h00000);
    add_step(OP_LOOKUP, 32'hABCD_E123, 32'h0,          12'h000, 1, R_MISS);
    add_step(OP_FAULT,  32'hABCD_E123, 32'h0,          12'h000, 0, R_DONE);
    add_step(OP_LOOKUP, 32'hABCD_E123, 32'h0,          12'h000, 0, R_DONE);
    add_base(FRAME_BASE_RST);
    add_step(OP_UNMAP,  32'h0000_0000, 32'h0,          12'h000, 1, R_INVAL);

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        set_frame_base(script[i].base);
      end else begin
        send_item(script[i].cmd, script[i].typed, script[i].want);
      end
    end

    // Random phases. Each re-bases the pool, which also reclaims every
    // frame, and then works over a few directory and table slots so that
    // maps, unmaps and lookups meet one another. Fill phases fault mostly
    // and run the pool dry, so the out-of-frames path is taken, including
    // the case where a fault needs a table as well as a page.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph % 5)
        0:       base = 20'h00000;
        1:       base = 20'hFFFFF;
        2:       base = 20'hFFFD0;
        3:       base = FRAME_W'($urandom);
        default: base = FRAME_BASE_RST;
      endcase
      set_frame_base(base);
      foreach (dirs[d]) dirs[d] = IDX_W'($urandom);
      foreach (tix[t]) tix[t] = IDX_W'($urandom);
      fill    = (ph == 3 || ph == 9);
      n_items = fill ? 70 : 42;
      // The last phase, and every third one, runs with no sender gaps.
      idles   = (ph != N_PHASES - 1) && (ph % 3 != 1);

      for (int k = 0; k < n_items; k++) begin
        // Hold back once mid-phase until every result is in.
        if (ph == 5 && k == 23) wait_idle();

        dice = $urandom_range(0, 99);
        if (fill) begin
          cmd.op = (dice < 80) ? OP_FAULT : (dice < 90) ? OP_LOOKUP : OP_MAP;
        end else begin
          cmd.op = (dice < 30) ? OP_MAP : (dice < 45) ? OP_UNMAP :
                   (dice < 80) ? OP_LOOKUP : OP_FAULT;
        end
        // Stray addresses land in fresh directory slots, each costing a
        // table clear, so they are kept to a modest share.
        if ($urandom_range(0, 99) < (fill ? 30 : 12)) begin
          cmd.virt_addr = $urandom;
        end else begin
          cmd.virt_addr = {dirs[$urandom_range(0, 3)], tix[$urandom_range(0, 5)],
                           12'($urandom)};
        end
        cmd.phys_addr   = $urandom;
        cmd.entry_flags = 12'($urandom);

        if (idles && $urandom_range(0, 2) == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 13)) @(negedge clk_i);
        end
        send_item(cmd, 1'b0, R_DONE);
      end
    end

    // Drain, then leave room for any stray strobe before the verdict.
    wait_idle();
    repeat (40) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
